@@ src/pcc_pkg.sv @@
package pcc_pkg;

	// Event kinds carried in the mode field
	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_POLL  = 2'd1,
		MODE_BG    = 2'd2,
		MODE_ARM   = 2'd3
	} mode_t;

	// Result codes
	typedef enum logic [3:0] {
		RES_NEED_BG     = 4'd0,
		RES_POLL        = 4'd1,
		RES_IDLE        = 4'd2,
		RES_SETTLE      = 4'd3,
		RES_KEPT        = 4'd4,
		RES_KEPT_FULL   = 4'd5,
		RES_COMPLETE    = 4'd6,
		RES_BOUNCED     = 4'd7,
		RES_BG_REFRESH  = 4'd8,
		RES_LIFT_WAIT   = 4'd9,
		RES_READY       = 4'd10,
		RES_BG_TAKEN    = 4'd11,
		RES_BG_REPLACED = 4'd12,
		RES_BG_KEPT     = 4'd13,
		RES_ARMED       = 4'd14
	} res_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_MIN_FRAMES     = 2'd0;
	localparam logic [1:0] CFG_MAX_FRAMES     = 2'd1;
	localparam logic [1:0] CFG_LIFT_CLEAR     = 2'd2;
	localparam logic [1:0] CFG_REFRESH_IDLE   = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

endpackage

@@ src/press_capture_controller_core.sv @@
// Path: an accepted request is held in the input register, then its result moves into
//   the result register, where out_valid shows it until it is taken.
// Throughput: one request per cycle; the result register frees the input side while a
//   finished result waits, and stall reaches the input only when both registers are full.
// Reset (arst_n low, asynchronous): pipeline empty, capture state and background cleared,
//   configuration back to min 3, max 8, lift 3, refresh 50 polls.
module press_capture_controller_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
	// input request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     mode,
	input  logic                           new_operation,
	input  logic                           touch_seen,
	input  logic [31:0]                    candidate_sum,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     event_res,
	output logic [7:0]                     frames_kept,
	output logic                           waiting_for_lift,
	output logic                           finger_present
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [7:0]  min_frames_q;
	logic [7:0]  max_frames_q;
	logic [7:0]  lift_clear_q;
	logic [15:0] refresh_idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frames_q   <= 8'd3;
			max_frames_q   <= 8'd8;
			lift_clear_q   <= 8'd3;
			refresh_idle_q <= 16'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				pcc_pkg::CFG_MIN_FRAMES:   min_frames_q   <= cfg_data[7:0];
				pcc_pkg::CFG_MAX_FRAMES:   max_frames_q   <= cfg_data[7:0];
				pcc_pkg::CFG_LIFT_CLEAR:   lift_clear_q   <= cfg_data[7:0];
				pcc_pkg::CFG_REFRESH_IDLE: refresh_idle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: input register (s1) feeds result register
	// ------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic in_accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// input payload register, no reset needed
	pcc_pkg::mode_t mode_s1;
	logic           new_op_s1;
	logic           touch_s1;
	logic [31:0]    cand_s1;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1   <= pcc_pkg::mode_t'(mode);
			new_op_s1 <= new_operation;
			touch_s1  <= touch_seen;
			cand_s1   <= candidate_sum;
		end
	end

	// ------------------------------------------------------------------
	// Capture state
	// ------------------------------------------------------------------
	logic        bg_valid_q,  bg_valid_d;
	logic [31:0] bg_sum_q,    bg_sum_d;
	logic        refresh_q,   refresh_d;
	logic [7:0]  frame_cnt_q, frame_cnt_d;
	logic        settled_q,   settled_d;
	logic        lift_q,      lift_d;
	logic [7:0]  clear_cnt_q, clear_cnt_d;
	logic [15:0] idle_cnt_q,  idle_cnt_d;

	pcc_pkg::res_t res_d;
	logic          present_d;

	// saturating increments
	logic [7:0]  frame_inc;
	logic [7:0]  clear_inc;
	logic [15:0] idle_inc;

	assign frame_inc = (frame_cnt_q == 8'hFF)    ? frame_cnt_q : frame_cnt_q + 8'd1;
	assign clear_inc = (clear_cnt_q == 8'hFF)    ? clear_cnt_q : clear_cnt_q + 8'd1;
	assign idle_inc  = (idle_cnt_q  == 16'hFFFF) ? idle_cnt_q  : idle_cnt_q + 16'd1;

	always_comb begin
		bg_valid_d  = bg_valid_q;
		bg_sum_d    = bg_sum_q;
		refresh_d   = refresh_q;
		frame_cnt_d = frame_cnt_q;
		settled_d   = settled_q;
		lift_d      = lift_q;
		clear_cnt_d = clear_cnt_q;
		idle_cnt_d  = idle_cnt_q;
		present_d   = 1'b0;
		res_d       = pcc_pkg::RES_NEED_BG;

		case (mode_s1)
			pcc_pkg::MODE_START: begin
				frame_cnt_d = 8'd0;
				settled_d   = 1'b0;
				idle_cnt_d  = 16'd0;
				refresh_d   = 1'b0;
				if (new_op_s1) begin
					lift_d      = 1'b0;
					clear_cnt_d = 8'd0;
				end
				res_d = bg_valid_q ? pcc_pkg::RES_POLL : pcc_pkg::RES_NEED_BG;
			end

			pcc_pkg::MODE_POLL: begin
				if (!bg_valid_q) begin
					// nothing to compare against yet
					res_d = pcc_pkg::RES_NEED_BG;
				end else if (lift_q) begin
					// waiting for a run of clear polls
					if (touch_s1) begin
						clear_cnt_d = 8'd0;
						res_d       = pcc_pkg::RES_LIFT_WAIT;
					end else if (clear_inc >= lift_clear_q) begin
						lift_d      = 1'b0;
						clear_cnt_d = 8'd0;
						res_d       = pcc_pkg::RES_READY;
					end else begin
						clear_cnt_d = clear_inc;
						res_d       = pcc_pkg::RES_LIFT_WAIT;
					end
				end else if (touch_s1) begin
					present_d = 1'b1;
					if (!settled_q) begin
						// first touch poll only settles the finger
						settled_d = 1'b1;
						res_d     = pcc_pkg::RES_SETTLE;
					end else begin
						frame_cnt_d = frame_inc;
						idle_cnt_d  = 16'd0;
						res_d = (frame_inc >= max_frames_q) ? pcc_pkg::RES_KEPT_FULL
						                                    : pcc_pkg::RES_KEPT;
					end
				end else if (frame_cnt_q >= min_frames_q) begin
					res_d = pcc_pkg::RES_COMPLETE;
				end else if (frame_cnt_q != 8'd0) begin
					// lifted too early: restart the capture
					frame_cnt_d = 8'd0;
					settled_d   = 1'b0;
					idle_cnt_d  = 16'd0;
					refresh_d   = 1'b0;
					res_d       = pcc_pkg::RES_BOUNCED;
				end else begin
					settled_d = 1'b0;
					if (idle_inc >= refresh_idle_q) begin
						idle_cnt_d = 16'd0;
						refresh_d  = 1'b1;
						res_d      = pcc_pkg::RES_BG_REFRESH;
					end else begin
						idle_cnt_d = idle_inc;
						res_d      = pcc_pkg::RES_IDLE;
					end
				end
			end

			pcc_pkg::MODE_BG: begin
				refresh_d = 1'b0;
				if (!bg_valid_q) begin
					bg_valid_d = 1'b1;
					bg_sum_d   = cand_s1;
					res_d      = pcc_pkg::RES_BG_TAKEN;
				end else if (cand_s1 <= bg_sum_q) begin
					// darker or equal frame replaces the stored one
					bg_sum_d = cand_s1;
					res_d    = pcc_pkg::RES_BG_REPLACED;
				end else begin
					res_d = pcc_pkg::RES_BG_KEPT;
				end
			end

			default: begin
				lift_d      = 1'b1;
				clear_cnt_d = 8'd0;
				res_d       = pcc_pkg::RES_ARMED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_valid_q  <= 1'b0;
			bg_sum_q    <= 32'd0;
			refresh_q   <= 1'b0;
			frame_cnt_q <= 8'd0;
			settled_q   <= 1'b0;
			lift_q      <= 1'b0;
			clear_cnt_q <= 8'd0;
			idle_cnt_q  <= 16'd0;
		end else if (advance) begin
			bg_valid_q  <= bg_valid_d;
			bg_sum_q    <= bg_sum_d;
			refresh_q   <= refresh_d;
			frame_cnt_q <= frame_cnt_d;
			settled_q   <= settled_d;
			lift_q      <= lift_d;
			clear_cnt_q <= clear_cnt_d;
			idle_cnt_q  <= idle_cnt_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	pcc_pkg::res_t res_q;
	logic [7:0]    frames_q;
	logic          lift_out_q;
	logic          present_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q      <= res_d;
			frames_q   <= frame_cnt_d;
			lift_out_q <= lift_d;
			present_q  <= present_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_res        = res_q;
	assign frames_kept      = frames_q;
	assign waiting_for_lift = lift_out_q;
	assign finger_present   = present_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a counted touch only comes with settle or keep results
	a_present_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finger_present |->
			(event_res == pcc_pkg::RES_SETTLE) || (event_res == pcc_pkg::RES_KEPT) ||
			(event_res == pcc_pkg::RES_KEPT_FULL))
		else $error("finger_present with a non-touch result");

	// arming always leaves the lift wait set
	a_armed_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == pcc_pkg::RES_ARMED) |-> waiting_for_lift)
		else $error("armed result without lift wait");

	// ready ends the lift wait
	a_ready_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == pcc_pkg::RES_READY) |-> !waiting_for_lift)
		else $error("ready result with lift wait still set");

	// a bounce restarts the frame count
	a_bounce_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == pcc_pkg::RES_BOUNCED) |-> (frames_kept == 8'd0))
		else $error("bounce result with frames kept");

endmodule

@@ bench/tb_press_capture_controller_core.sv @@
module tb_press_capture_controller_core;

	// One result as the capture logic should report it
	typedef struct packed {
		pcc_pkg::res_t code;
		logic [7:0]    frames;
		logic          lift;
		logic          present;
	} capture_result_t;

	// One row of the directed script; fixed rows carry their own expected result
	typedef struct packed {
		pcc_pkg::mode_t  m;
		logic            nop;
		logic            touch;
		logic [31:0]     cand;
		logic            fixed;
		capture_result_t want;
	} script_row_t;

	localparam capture_result_t NO_CHECK = '{pcc_pkg::RES_NEED_BG, 8'd0, 1'b0, 1'b0};
	localparam int CYCLE_LIMIT = 200000;
	// two register stages in the block, plus margin
	localparam int DRAIN_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = 2'd0;
	logic        new_operation = 1'b0;
	logic        touch_seen = 1'b0;
	logic [31:0] candidate_sum = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  event_res;
	logic [7:0]  frames_kept;
	logic        waiting_for_lift;
	logic        finger_present;

	press_capture_controller_core uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Capture predictor: its own copy of thresholds and capture state
	// ---------------------------------------------------------------------------------
	logic [7:0]  min_keep, max_keep, lift_need;
	logic [15:0] refresh_need;
	logic        bg_held, refresh_due, settled_q, lift_armed;
	logic [31:0] bg_level;
	logic [7:0]  frame_cnt, clear_run;
	logic [15:0] idle_run;

	capture_result_t pending_results[$];
	capture_result_t got_want;
	int requests_sent = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;

	function automatic void restart_capture();
		frame_cnt = 8'd0;
		settled_q = 1'b0;
		idle_run = 16'd0;
		refresh_due = 1'b0;
	endfunction

	// Poll rules in priority order: no background, lift wait, touch, lift after touch,
	// bounce, idle with background refresh
	function automatic pcc_pkg::res_t poll_outcome(input logic touch, output logic seen);
		seen = 1'b0;
		if (!bg_held)
			return pcc_pkg::RES_NEED_BG;
		if (lift_armed) begin
			if (touch) begin
				clear_run = 8'd0;
				return pcc_pkg::RES_LIFT_WAIT;
			end
			if (clear_run != 8'hFF)
				clear_run++;
			if (clear_run >= lift_need) begin
				lift_armed = 1'b0;
				clear_run = 8'd0;
				return pcc_pkg::RES_READY;
			end
			return pcc_pkg::RES_LIFT_WAIT;
		end
		if (touch) begin
			seen = 1'b1;
			if (!settled_q) begin
				settled_q = 1'b1;
				return pcc_pkg::RES_SETTLE;
			end
			if (frame_cnt != 8'hFF)
				frame_cnt++;
			idle_run = 16'd0;
			return (frame_cnt >= max_keep) ? pcc_pkg::RES_KEPT_FULL : pcc_pkg::RES_KEPT;
		end
		if (frame_cnt >= min_keep)
			return pcc_pkg::RES_COMPLETE;
		if (frame_cnt != 8'd0) begin
			restart_capture();
			return pcc_pkg::RES_BOUNCED;
		end
		settled_q = 1'b0;
		if (idle_run != 16'hFFFF)
			idle_run++;
		if (idle_run >= refresh_need) begin
			idle_run = 16'd0;
			refresh_due = 1'b1;
			return pcc_pkg::RES_BG_REFRESH;
		end
		return pcc_pkg::RES_IDLE;
	endfunction

	function automatic capture_result_t capture_step(input pcc_pkg::mode_t m,
			input logic nop, input logic touch, input logic [31:0] cand);
		capture_result_t r;
		logic seen;
		seen = 1'b0;
		case (m)
			pcc_pkg::MODE_START: begin
				restart_capture();
				if (nop) begin
					lift_armed = 1'b0;
					clear_run = 8'd0;
				end
				r.code = bg_held ? pcc_pkg::RES_POLL : pcc_pkg::RES_NEED_BG;
			end
			pcc_pkg::MODE_POLL: r.code = poll_outcome(touch, seen);
			pcc_pkg::MODE_BG: begin
				refresh_due = 1'b0;
				if (!bg_held) begin
					bg_held = 1'b1;
					bg_level = cand;
					r.code = pcc_pkg::RES_BG_TAKEN;
				end else if (cand <= bg_level) begin
					bg_level = cand;
					r.code = pcc_pkg::RES_BG_REPLACED;
				end else begin
					r.code = pcc_pkg::RES_BG_KEPT;
				end
			end
			default: begin
				lift_armed = 1'b1;
				clear_run = 8'd0;
				r.code = pcc_pkg::RES_ARMED;
			end
		endcase
		r.frames = frame_cnt;
		r.lift = lift_armed;
		r.present = seen;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Request side. Tasks are entered and left at a falling edge.
	// ---------------------------------------------------------------------------------
	task automatic push_request(input pcc_pkg::mode_t m, input logic nop,
			input logic touch, input logic [31:0] cand, input logic fixed,
			input capture_result_t fixed_want);
		capture_result_t r;
		// idle decision is taken before valid rises, never from stall
		while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		new_operation <= nop;
		touch_seen <= touch;
		candidate_sum <= cand;
		do @(posedge clk); while (in_stall);
		// accepted at this edge: predict now so the state follows request order
		r = capture_step(m, nop, touch, cand);
		pending_results.push_back(fixed ? fixed_want : r);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic start_req(input logic nop);
		push_request(pcc_pkg::MODE_START, nop, 1'($urandom_range(1, 0)), $urandom, 1'b0,
			NO_CHECK);
	endtask

	task automatic poll_req(input logic touch);
		push_request(pcc_pkg::MODE_POLL, 1'($urandom_range(1, 0)), touch, $urandom, 1'b0,
			NO_CHECK);
	endtask

	task automatic bg_req(input logic [31:0] cand);
		push_request(pcc_pkg::MODE_BG, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
			cand, 1'b0, NO_CHECK);
	endtask

	task automatic arm_req();
		push_request(pcc_pkg::MODE_ARM, 1'($urandom_range(1, 0)),
			1'($urandom_range(1, 0)), $urandom, 1'b0, NO_CHECK);
	endtask

	// Hold off new requests until every result is back, then let the pipe go quiet
	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Back-to-back writes of all four thresholds; only called with the pipe empty.
	// The 8-bit registers get junk in the upper byte of the data bus.
	task automatic load_thresholds(input logic [7:0] min_v, input logic [7:0] max_v,
			input logic [7:0] lift_v, input logic [15:0] refresh_v);
		logic [7:0] junk;
		junk = 8'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= pcc_pkg::CFG_MIN_FRAMES;
		cfg_data <= {junk, min_v};
		@(negedge clk);
		cfg_index <= pcc_pkg::CFG_MAX_FRAMES;
		cfg_data <= {~junk, max_v};
		@(negedge clk);
		cfg_index <= pcc_pkg::CFG_LIFT_CLEAR;
		cfg_data <= {junk ^ 8'h5A, lift_v};
		@(negedge clk);
		cfg_index <= pcc_pkg::CFG_REFRESH_IDLE;
		cfg_data <= refresh_v;
		@(negedge clk);
		cfg_we <= 1'b0;
		min_keep = min_v;
		max_keep = max_v;
		lift_need = lift_v;
		refresh_need = refresh_v;
	endtask

	// Random traffic built mostly from well-formed presses, idle stretches and lift
	// waits, with some loose noise mixed in
	task automatic run_phase(input int last_item);
		int pick, cap;
		logic [31:0] cand;
		while (requests_sent < last_item) begin
			pick = $urandom_range(9, 0);
			if (pick < 4) begin
				// press: start, maybe a fresh background, touches with rare gaps, lift
				start_req($urandom_range(3, 0) != 0);
				if (!bg_held || $urandom_range(3, 0) == 0)
					bg_req($urandom);
				cap = (max_keep > 30) ? 30 : max_keep;
				repeat ($urandom_range(cap + 2, 1)) poll_req($urandom_range(9, 0) != 0);
				repeat ($urandom_range(3, 1)) poll_req(1'b0);
			end else if (pick == 4) begin
				// idle stretch, at times long enough to trip the background refresh
				start_req(1'($urandom_range(1, 0)));
				cap = (refresh_need > 60) ? 60 : refresh_need;
				repeat ($urandom_range(cap + 2, 1)) poll_req($urandom_range(19, 0) == 0);
			end else if (pick < 7) begin
				// arm, then clear polls with the odd touch breaking the run
				arm_req();
				cap = (lift_need > 20) ? 20 : lift_need;
				repeat ($urandom_range(cap + 3, 1)) poll_req($urandom_range(6, 0) == 0);
			end else if (pick == 7) begin
				case ($urandom_range(3, 0))
					0: cand = bg_level;
					1: cand = bg_level & $urandom;
					2: cand = bg_level | $urandom;
					default: cand = $urandom;
				endcase
				bg_req(cand);
			end else begin
				repeat ($urandom_range(4, 1))
					push_request(pcc_pkg::mode_t'($urandom_range(3, 0)),
						1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), $urandom,
						1'b0, NO_CHECK);
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		out_stall <= (recv_gap_pct != 0) && ($urandom_range(99, 0) < recv_gap_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request outstanding, event_res %0d",
					$time, event_res);
				mismatches++;
			end else begin
				got_want = pending_results.pop_front();
				if (event_res !== got_want.code) begin
					$display("%0t: event_res expected %0d got %0d", $time,
						got_want.code, event_res);
					mismatches++;
				end
				if (frames_kept !== got_want.frames) begin
					$display("%0t: frames_kept expected %0d got %0d", $time,
						got_want.frames, frames_kept);
					mismatches++;
				end
				if (waiting_for_lift !== got_want.lift) begin
					$display("%0t: waiting_for_lift expected %0b got %0b", $time,
						got_want.lift, waiting_for_lift);
					mismatches++;
				end
				if (finger_present !== got_want.present) begin
					$display("%0t: finger_present expected %0b got %0b", $time,
						got_want.present, finger_present);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Directed script, run at the reset thresholds (min 3, max 8, lift 3, refresh 50)
	// ---------------------------------------------------------------------------------
	script_row_t directed_script [26] = '{
		// poll, start and arm before any background is held
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'hA5A5_5A5A, 1'b1,
			'{pcc_pkg::RES_NEED_BG, 8'd0, 1'b0, 1'b0}},
		'{pcc_pkg::MODE_START, 1'b0, 1'b0, 32'h5A5A_A5A5, 1'b1,
			'{pcc_pkg::RES_NEED_BG, 8'd0, 1'b0, 1'b0}},
		'{pcc_pkg::MODE_ARM,   1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
			'{pcc_pkg::RES_ARMED, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_POLL,  1'b1, 1'b0, 32'h0000_0000, 1'b1,
			'{pcc_pkg::RES_NEED_BG, 8'd0, 1'b1, 1'b0}},
		// background: first taken, equal replaces, darker replaces, brighter kept
		'{pcc_pkg::MODE_BG,    1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1,
			'{pcc_pkg::RES_BG_TAKEN, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_BG,    1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
			'{pcc_pkg::RES_BG_REPLACED, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_BG,    1'b0, 1'b1, 32'h0000_0000, 1'b1,
			'{pcc_pkg::RES_BG_REPLACED, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_BG,    1'b1, 1'b0, 32'h0000_0001, 1'b1,
			'{pcc_pkg::RES_BG_KEPT, 8'd0, 1'b1, 1'b0}},
		// lift wait: touch holds it, clear run broken by a touch
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h1234_5678, 1'b1,
			'{pcc_pkg::RES_LIFT_WAIT, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b1, 1'b1, 32'h0,         1'b0, NO_CHECK},
		// new operation drops the wait
		'{pcc_pkg::MODE_START, 1'b1, 1'b0, 32'h0,         1'b1,
			'{pcc_pkg::RES_POLL, 8'd0, 1'b0, 1'b0}},
		'{pcc_pkg::MODE_ARM,   1'b0, 1'b0, 32'h0,         1'b1,
			'{pcc_pkg::RES_ARMED, 8'd0, 1'b1, 1'b0}},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		// settle, one frame, lift too early: bounce
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		// settle, three frames, lift completes
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b1, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_POLL,  1'b0, 1'b0, 32'h0,         1'b0, NO_CHECK},
		'{pcc_pkg::MODE_START, 1'b0, 1'b1, 32'h0,         1'b1,
			'{pcc_pkg::RES_POLL, 8'd0, 1'b0, 1'b0}}
	};

	int phase_len [6] = '{190, 190, 560, 190, 190, 190};

	initial begin
		min_keep = 8'd3;
		max_keep = 8'd8;
		lift_need = 8'd3;
		refresh_need = 16'd50;
		bg_held = 1'b0;
		bg_level = '0;
		refresh_due = 1'b0;
		frame_cnt = '0;
		settled_q = 1'b0;
		lift_armed = 1'b0;
		clear_run = '0;
		idle_run = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles lightly, receiver stalls heavily
		send_gap_pct = 36;
		recv_gap_pct = 79;
		foreach (directed_script[i])
			push_request(directed_script[i].m, directed_script[i].nop,
				directed_script[i].touch, directed_script[i].cand,
				directed_script[i].fixed, directed_script[i].want);
		settle_pipeline();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_gap_pct = 79;
				recv_gap_pct = 36;
			end else if (ph == 4) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			case (ph)
				0: load_thresholds(8'd3, 8'd8, 8'd3, 16'd50);
				1: load_thresholds(8'd0, 8'd0, 8'd0, 16'd0);
				2: load_thresholds(8'd255, 8'd255, 8'd255, 16'd65535);
				3: load_thresholds(8'd1, 8'd1, 8'd1, 16'd1);
				4: load_thresholds(8'd2, 8'd5, 8'd2, 16'd7);
				default: load_thresholds(8'($urandom_range(6, 1)), 8'($urandom_range(12, 1)),
					8'($urandom_range(4, 1)), 16'($urandom_range(20, 2)));
			endcase
			if (ph == 1) begin
				// pause mid-phase until the pipe is empty, then carry on
				run_phase(requests_sent + phase_len[ph] / 2);
				settle_pipeline();
			end
			if (ph == 2) begin
				// top thresholds: frame counter saturates, full lift run of 255
				start_req(1'b1);
				repeat (260) poll_req(1'b1);
				poll_req(1'b0);
				arm_req();
				repeat (256) poll_req(1'b0);
			end
			run_phase(requests_sent + phase_len[ph] - (ph == 2 ? 520 : 0));
			settle_pipeline();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
